// ----- rtl/core/sm83_pkg.sv -----
// Package for the SM83 subset instruction core: types, phase codes and flag masks.
// No dependencies; used by every module in rtl/core.
package sm83_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FETCH = 3'd1,
    PH_OP1   = 3'd2,
    PH_OP2   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CB    = 3'd5,
    PH_FAULT = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ACC_READ  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_FAULT = 2'd2
  } access_e;

  localparam logic [7:0] FLAG_Z = 8'h80;
  localparam logic [7:0] FLAG_N = 8'h40;
  localparam logic [7:0] FLAG_H = 8'h20;
  localparam logic [7:0] FLAG_C = 8'h10;
  localparam logic [7:0] LINE_LAST = 8'd153;

  // One bus access produced by an input byte.
  typedef struct packed {
    access_e     kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        done;
    logic [4:0]  cycles;
    logic [7:0]  line;
  } result_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] pc;
    logic [15:0] sp;
    logic        ie;
    phase_e      phase;
    logic [7:0]  op;
    logic [7:0]  lo;
    logic [7:0]  line;
  } arch_t;

  localparam arch_t ARCH_RESET = '{a: 8'h01, f: 8'hB0, b: 8'h00, c: 8'h13, d: 8'h00,
    e: 8'hD8, h: 8'h01, l: 8'h4D, pc: 16'h0100, sp: 16'hFFFE, ie: 1'b1,
    phase: PH_IDLE, op: 8'h00, lo: 8'h00, line: 8'h00};

endpackage

// ----- rtl/core/sm83_exec.sv -----
// Combinational execute step of the SM83 subset core: one input byte to new state and up to
// three bus results. Depends on sm83_pkg.
module sm83_exec (
  input  sm83_pkg::arch_t    st_i,
  input  logic               mode_i,
  input  logic [7:0]         data_i,
  output sm83_pkg::arch_t    st_o,
  output sm83_pkg::result_t  res_o [3],
  output logic [1:0]         count_o
);
  import sm83_pkg::*;

  arch_t       s;
  result_t     r [3];
  logic [1:0]  n;
  logic [4:0]  fin_cyc;
  logic        fin;
  logic        flt;
  logic [7:0]  flt_byte;
  logic [7:0]  line_nx;
  logic [15:0] hl, de, a16, pc1, off;
  logic [8:0]  sum;
  logic        take;

  always_comb begin
    s        = st_i;
    n        = 2'd0;
    fin      = 1'b0;
    fin_cyc  = 5'd0;
    flt      = 1'b0;
    flt_byte = 8'h00;
    take     = 1'b0;
    sum      = 9'd0;
    for (int i = 0; i < 3; i++) r[i] = '{ACC_READ, 16'h0, 8'h0, 1'b0, 5'd0, 8'h0};
    hl  = {st_i.h, st_i.l};
    de  = {st_i.d, st_i.e};
    a16 = {data_i, st_i.lo};
    pc1 = st_i.pc + 16'd1;
    off = {{8{data_i[7]}}, data_i};
    if (st_i.phase == PH_FAULT) begin
      r[0] = '{ACC_FAULT, st_i.pc - 16'd1, st_i.op, 1'b0, 5'd0, 8'h0};
      n = 2'd1;
    end else if (!mode_i) begin
      if (st_i.phase == PH_IDLE) begin
        r[0] = '{ACC_READ, st_i.pc, 8'h0, 1'b0, 5'd0, 8'h0};
        n = 2'd1;
        s.phase = PH_FETCH;
      end
    end else begin
      unique case (st_i.phase)
        PH_FETCH: begin
          s.op = data_i;
          s.pc = pc1;
          case (data_i)
            8'h00: begin fin = 1'b1; fin_cyc = 5'd4; end
            8'h04, 8'h0C, 8'h05, 8'h0D, 8'h3D: begin
              logic [7:0] v, q;
              logic       dn;
              dn = data_i[0];
              v = (data_i == 8'h04) ? st_i.b : (data_i == 8'h3D) ? st_i.a :
                  (data_i == 8'h05) ? st_i.b : st_i.c;
              q = dn ? v - 8'd1 : v + 8'd1;
              s.f = (st_i.f & FLAG_C) | (dn ? FLAG_N : 8'h00) | ((q == 8'h00) ? FLAG_Z : 8'h00)
                    | ((dn ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF)) ? FLAG_H : 8'h00);
              if (data_i == 8'h04 || data_i == 8'h05) s.b = q;
              else if (data_i == 8'h3D) s.a = q;
              else s.c = q;
              fin = 1'b1; fin_cyc = 5'd4;
            end
            8'h06, 8'h0E, 8'h1E, 8'h2E, 8'h3E, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38,
            8'hE0, 8'hF0, 8'hFE, 8'h08, 8'h11, 8'h21, 8'h31, 8'hC3, 8'hCD, 8'hEA,
            8'hCB: begin
              r[0] = '{ACC_READ, pc1, 8'h0, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              s.pc = pc1 + 16'd1;
              s.phase = (data_i == 8'hCB) ? PH_CB : PH_OP1;
            end
            8'h13: begin {s.d, s.e} = de + 16'd1; fin = 1'b1; fin_cyc = 5'd8; end
            8'h23: begin {s.h, s.l} = hl + 16'd1; fin = 1'b1; fin_cyc = 5'd8; end
            8'h17: begin
              s.a = {st_i.a[6:0], st_i.f[4]};
              s.f = st_i.a[7] ? FLAG_C : 8'h00;
              fin = 1'b1; fin_cyc = 5'd4;
            end
            8'h1A: begin
              r[0] = '{ACC_READ, de, 8'h0, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              s.phase = PH_DATA;
            end
            8'h22, 8'h32, 8'h77: begin
              r[0] = '{ACC_WRITE, hl, st_i.a, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              if (data_i == 8'h22) {s.h, s.l} = hl + 16'd1;
              if (data_i == 8'h32) {s.h, s.l} = hl - 16'd1;
              fin = 1'b1; fin_cyc = 5'd8;
            end
            8'h2F: begin
              s.a = ~st_i.a; s.f = st_i.f | FLAG_N | FLAG_H;
              fin = 1'b1; fin_cyc = 5'd4;
            end
            8'h41: begin s.b = st_i.c; fin = 1'b1; fin_cyc = 5'd4; end
            8'h4C: begin s.c = st_i.b; fin = 1'b1; fin_cyc = 5'd4; end
            8'h4F: begin s.c = st_i.a; fin = 1'b1; fin_cyc = 5'd4; end
            8'h51: begin s.d = st_i.c; fin = 1'b1; fin_cyc = 5'd4; end
            8'h57: begin s.d = st_i.a; fin = 1'b1; fin_cyc = 5'd4; end
            8'h5C: begin s.e = st_i.h; fin = 1'b1; fin_cyc = 5'd4; end
            8'h60: begin s.h = st_i.b; fin = 1'b1; fin_cyc = 5'd4; end
            8'h67: begin s.h = st_i.a; fin = 1'b1; fin_cyc = 5'd4; end
            8'h7A: begin s.a = st_i.d; fin = 1'b1; fin_cyc = 5'd4; end
            8'h7B: begin s.a = st_i.e; fin = 1'b1; fin_cyc = 5'd4; end
            8'h87: begin
              sum = {1'b0, st_i.a} + {1'b0, st_i.a};
              s.a = sum[7:0];
              s.f = (sum[8] ? FLAG_C : 8'h00) | ((sum[7:0] == 8'h00) ? FLAG_Z : 8'h00)
                    | (st_i.a[3] ? FLAG_H : 8'h00);
              fin = 1'b1; fin_cyc = 5'd4;
            end
            8'hAF: begin s.a = 8'h00; s.f = FLAG_Z; fin = 1'b1; fin_cyc = 5'd4; end
            8'hB1: begin
              s.a = st_i.a | st_i.c;
              s.f = ((st_i.a | st_i.c) == 8'h00) ? FLAG_Z : 8'h00;
              fin = 1'b1; fin_cyc = 5'd4;
            end
            8'hC1, 8'hC9, 8'hD0: begin
              if (data_i == 8'hD0 && st_i.f[4]) begin
                fin = 1'b1; fin_cyc = 5'd8;
              end else begin
                r[0] = '{ACC_READ, st_i.sp, 8'h0, 1'b0, 5'd0, 8'h0};
                n = 2'd1;
                s.sp = st_i.sp + 16'd1;
                s.phase = PH_OP1;
              end
            end
            8'hC5, 8'hFF: begin
              s.sp = st_i.sp - 16'd2;
              r[0] = '{ACC_WRITE, s.sp, (data_i == 8'hC5) ? st_i.c : pc1[7:0], 1'b0, 5'd0,
                       8'h0};
              r[1] = '{ACC_WRITE, st_i.sp - 16'd1, (data_i == 8'hC5) ? st_i.b : pc1[15:8],
                       1'b0, 5'd0, 8'h0};
              n = 2'd2;
              if (data_i == 8'hFF) s.pc = 16'h0038;
              fin = 1'b1; fin_cyc = 5'd16;
            end
            8'hE2: begin
              r[0] = '{ACC_WRITE, {8'hFF, st_i.c}, st_i.a, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              fin = 1'b1; fin_cyc = 5'd8;
            end
            8'hE9: begin s.pc = hl; fin = 1'b1; fin_cyc = 5'd4; end
            8'hF3: begin s.ie = 1'b0; fin = 1'b1; fin_cyc = 5'd4; end
            default: begin flt = 1'b1; flt_byte = data_i; s.pc = pc1; end
          endcase
        end
        PH_OP1: begin
          case (st_i.op)
            8'h06: begin s.b = data_i; fin = 1'b1; fin_cyc = 5'd8; end
            8'h0E: begin s.c = data_i; fin = 1'b1; fin_cyc = 5'd8; end
            8'h1E: begin s.e = data_i; fin = 1'b1; fin_cyc = 5'd8; end
            8'h2E: begin s.l = data_i; fin = 1'b1; fin_cyc = 5'd8; end
            8'h3E: begin s.a = data_i; fin = 1'b1; fin_cyc = 5'd8; end
            8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
              take = (st_i.op == 8'h18) || (st_i.op == 8'h20 && !st_i.f[7]) ||
                     (st_i.op == 8'h28 && st_i.f[7]) || (st_i.op == 8'h30 && !st_i.f[4]) ||
                     (st_i.op == 8'h38 && st_i.f[4]);
              if (take) s.pc = st_i.pc + off;
              fin = 1'b1; fin_cyc = take ? 5'd12 : 5'd8;
            end
            8'hE0: begin
              r[0] = '{ACC_WRITE, {8'hFF, data_i}, st_i.a, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              fin = 1'b1; fin_cyc = 5'd12;
            end
            8'hF0: begin
              r[0] = '{ACC_READ, {8'hFF, data_i}, 8'h0, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              s.phase = PH_DATA;
            end
            8'hFE: begin
              s.f = FLAG_N | ((st_i.a == data_i) ? FLAG_Z : 8'h00)
                    | ((st_i.a < data_i) ? FLAG_C : 8'h00)
                    | ((st_i.a[3:0] < data_i[3:0]) ? FLAG_H : 8'h00);
              fin = 1'b1; fin_cyc = 5'd8;
            end
            8'hC1, 8'hC9, 8'hD0: begin
              s.lo = data_i;
              r[0] = '{ACC_READ, st_i.sp, 8'h0, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              s.sp = st_i.sp + 16'd1;
              s.phase = PH_OP2;
            end
            default: begin
              s.lo = data_i;
              r[0] = '{ACC_READ, st_i.pc, 8'h0, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              s.pc = pc1;
              s.phase = PH_OP2;
            end
          endcase
        end
        PH_OP2: begin
          case (st_i.op)
            8'h08: begin
              r[0] = '{ACC_WRITE, a16 + 16'd1, st_i.sp[15:8], 1'b0, 5'd0, 8'h0};
              r[1] = '{ACC_WRITE, a16, st_i.sp[7:0], 1'b0, 5'd0, 8'h0};
              n = 2'd2;
              fin = 1'b1; fin_cyc = 5'd12;
            end
            8'h11: begin s.d = data_i; s.e = st_i.lo; fin = 1'b1; fin_cyc = 5'd12; end
            8'h21: begin s.h = data_i; s.l = st_i.lo; fin = 1'b1; fin_cyc = 5'd12; end
            8'h31: begin s.sp = a16; fin = 1'b1; fin_cyc = 5'd12; end
            8'hC3: begin s.pc = a16; fin = 1'b1; fin_cyc = 5'd16; end
            8'hEA: begin
              r[0] = '{ACC_WRITE, a16, st_i.a, 1'b0, 5'd0, 8'h0};
              n = 2'd1;
              fin = 1'b1; fin_cyc = 5'd16;
            end
            8'hCD: begin
              s.sp = st_i.sp - 16'd2;
              r[0] = '{ACC_WRITE, s.sp, st_i.pc[7:0], 1'b0, 5'd0, 8'h0};
              r[1] = '{ACC_WRITE, st_i.sp - 16'd1, st_i.pc[15:8], 1'b0, 5'd0, 8'h0};
              n = 2'd2;
              s.pc = a16;
              fin = 1'b1; fin_cyc = 5'd24;
            end
            8'hC1: begin s.b = data_i; s.c = st_i.lo; fin = 1'b1; fin_cyc = 5'd12; end
            8'hC9: begin s.pc = a16; fin = 1'b1; fin_cyc = 5'd16; end
            default: begin s.pc = a16; fin = 1'b1; fin_cyc = 5'd20; end
          endcase
        end
        PH_DATA: begin
          s.a = data_i;
          fin = 1'b1; fin_cyc = (st_i.op == 8'hF0) ? 5'd12 : 5'd8;
        end
        PH_CB: begin
          if (data_i == 8'h11) begin
            s.c = {st_i.c[6:0], st_i.f[4]};
            s.f = (st_i.c[7] ? FLAG_C : 8'h00)
                  | (({st_i.c[6:0], st_i.f[4]} == 8'h00) ? FLAG_Z : 8'h00);
            fin = 1'b1; fin_cyc = 5'd4;
          end else if (data_i == 8'h7C) begin
            s.f = (st_i.f & FLAG_C) | FLAG_H | (st_i.h[7] ? 8'h00 : FLAG_Z);
            fin = 1'b1; fin_cyc = 5'd4;
          end else begin
            flt = 1'b1; flt_byte = data_i;
          end
        end
        PH_IDLE: ;
        default: s.phase = PH_IDLE;
      endcase
      line_nx = (st_i.line >= LINE_LAST) ? 8'd0 : st_i.line + 8'd1;
      if (fin) begin
        s.line  = line_nx;
        s.phase = PH_FETCH;
        r[n]    = '{ACC_READ, s.pc, 8'h0, 1'b1, fin_cyc, line_nx};
        n       = n + 2'd1;
      end
      if (flt) begin
        s.op    = flt_byte;
        s.phase = PH_FAULT;
        r[0]    = '{ACC_FAULT, s.pc - 16'd1, flt_byte, 1'b0, 5'd0, 8'h0};
        n       = 2'd1;
      end
    end
    line_nx = (st_i.line >= LINE_LAST) ? 8'd0 : st_i.line + 8'd1;
  end

  assign st_o    = s;
  assign res_o   = r;
  assign count_o = n;

endmodule

// ----- rtl/core/sm83_outq.sv -----
// Result queue of the SM83 subset core: holds up to three results of one input and
// presents them one per transfer. Depends on sm83_pkg.
module sm83_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sm83_pkg::result_t  res_i [3],
  input  logic [1:0]         count_i,
  output logic               empty_o,
  output logic               last_o,
  output logic               valid_o,
  input  logic               ready_i,
  output sm83_pkg::result_t  head_o
);
  import sm83_pkg::*;

  result_t    buf_q [3];
  result_t    buf_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] rd_q, rd_d;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (valid_o && ready_i) begin
      cnt_d = cnt_q - 2'd1;
      rd_d  = rd_q + 2'd1;
    end
    if (load_i) begin
      buf_d = res_i;
      cnt_d = count_i;
      rd_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign valid_o = (cnt_q != 2'd0);
  assign empty_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);
  assign last_o  = (cnt_q == 2'd1);
  assign head_o  = buf_q[(rd_q == 2'd3) ? 2'd0 : rd_q];

endmodule

// ----- rtl/core/sm83_subset_instruction_core.sv -----
// Top level of the SM83 subset instruction core: state register, execute step and
// result queue. Depends on sm83_pkg, sm83_exec and sm83_outq.
//
// Usage: each slave transfer carries one input item, tuser = mode (0 starts the core
// with an opcode fetch, 1 returns the byte for the outstanding read) and
// tdata = read_data. Every input yields zero to three master transfers: bus read
// requests, bus writes, or a fault report, the final one marked by m_axis_tlast.
// The opcode fetch that opens an instruction also reports the cycles and scanline
// count of the one just finished.
// An accepted input is executed in the cycle of its transfer and its first result
// appears on the master side in the cycle after.
// Throughput: one input per cycle while m_axis_tready is high and its results leave
// in a single transfer; an input with more results holds the master side until all
// have left, and the next input is taken in the cycle the last one is transferred.
// Reset puts the registers to their power-up values and the core waits for a start.
// When the receiver stalls, the result queue holds its entries and s_axis_tready falls
// until the last result can leave.
module sm83_subset_instruction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] read_data
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] address, [23:16] write_data,
                                      // [28:24] cycles, [36:29] line_count, rest zero
  output logic [2:0]  m_axis_tuser,   // [1:0] access_kind, [2] instr_done
  output logic        m_axis_tlast
);
  import sm83_pkg::*;

  arch_t      st_q, st_d;
  result_t    res [3];
  result_t    head;
  logic [1:0] cnt;
  logic       empty, lastr, accept;

  assign s_axis_tready = empty;
  assign accept = s_axis_tvalid && s_axis_tready;

  sm83_exec u_exec (
    .st_i(st_q), .mode_i(s_axis_tuser), .data_i(s_axis_tdata),
    .st_o(st_d), .res_o(res), .count_o(cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ARCH_RESET;
    else if (accept) st_q <= st_d;
  end

  sm83_outq u_outq (
    .clk_i(clk_i), .rst_ni(rst_ni), .load_i(accept), .res_i(res), .count_i(cnt),
    .empty_o(empty), .last_o(lastr), .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .head_o(head)
  );

  assign m_axis_tdata = {3'b000, head.line, head.cycles, head.wdata, head.addr};
  assign m_axis_tuser = {head.done, head.kind};
  assign m_axis_tlast = lastr;

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.line <= LINE_LAST) else $error("scanline counter out of range");
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_FAULT |=> st_q.phase == PH_FAULT) else $error("fault left");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready) else $error("accept while busy");

endmodule
